// ----- src/bsst_pkg.sv -----
// Shared field widths, opcodes and compare outcome type for the sorted table search block.
`default_nettype none
package bsst_pkg;

  localparam int INDEX_W = 10;
  localparam int HIGH_W  = 11;
  localparam int VALUE_W = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic hit;
    logic go_left;
  } bsst_cmp_t;

endpackage
`default_nettype wire

// ----- src/bsst_step.sv -----
// One probe step: compare the fetched element with the key and narrow the range.
`default_nettype none
module bsst_step #(
  parameter int RW = 12,
  parameter int EW = 32
) (
  input  wire logic signed [EW-1:0] elem_i,
  input  wire logic signed [EW-1:0] key_i,
  input  wire logic signed [RW-1:0] lo_i,
  input  wire logic signed [RW-1:0] hi_i,
  input  wire logic signed [RW-1:0] mid_i,
  output bsst_pkg::bsst_cmp_t       cmp_o,
  output logic signed [RW-1:0]      lo_o,
  output logic signed [RW-1:0]      hi_o,
  output logic signed [RW-1:0]      mid_o,
  output logic                      empty_o
);
  import bsst_pkg::*;

  localparam logic signed [RW-1:0] One = RW'(1);

  logic signed [RW-1:0] sum;

  always_comb begin
    cmp_o.hit     = (elem_i == key_i);
    cmp_o.go_left = (elem_i > key_i);
    lo_o          = cmp_o.go_left ? lo_i : (mid_i + One);
    hi_o          = cmp_o.go_left ? (mid_i - One) : hi_i;
    empty_o       = (lo_o > hi_o);
    sum           = lo_o + hi_o;
    mid_o         = sum >>> 1;
  end

endmodule
`default_nettype wire

// ----- src/binary_search_sorted_table_core.sv -----
// Top level: element table memory and probe sequencer for binary search.
// A write item is stored as it is accepted; the block stays ready for the next item.
// A search item holds off input while the sequencer makes P probes, P being the probe count
// (at most floor(log2(range length))+1, i.e. 11 for 1024 entries), one probe per cycle
// through the single table read port; an empty range makes no probe. The result then waits for a free output slot.
// Reset clears the sequencer and output valid flag; table contents stay undefined until written.
`default_nettype none
module binary_search_sorted_table_core #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                opcode_i,
  input  wire logic [bsst_pkg::INDEX_W-1:0]        write_index_i,
  input  wire logic signed [bsst_pkg::VALUE_W-1:0] write_value_i,
  input  wire logic signed [bsst_pkg::VALUE_W-1:0] search_key_i,
  input  wire logic [bsst_pkg::INDEX_W-1:0]        low_index_i,
  input  wire logic signed [bsst_pkg::HIGH_W-1:0]  high_index_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     found_o,
  output logic [bsst_pkg::INDEX_W-1:0]             position_o
);
  import bsst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int BASE_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int RW = BASE_W + 2;
  localparam int EW = ELEMENT_WIDTH;
  localparam logic signed [RW-1:0] DMax = RW'(TABLE_DEPTH - 1);
  localparam logic [RW-1:0] Depth = RW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0] state_q, state_d;

  logic signed [EW-1:0] mem [TABLE_DEPTH];
  logic signed [EW-1:0] rd_q;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     wr_addr, rd_addr;

  logic signed [EW-1:0] wr_elem, key_in, key_q;
  logic signed [RW-1:0] lo_q, hi_q, mid_q;
  logic signed [RW-1:0] lo0, hi_ext, hi0, mid0, sum0;
  logic                 empty0;
  logic [RW-1:0]        wr_idx_ext;
  logic                 wr_ok;

  bsst_cmp_t            cmp;
  logic signed [RW-1:0] lo_n, hi_n, mid_n;
  logic                 empty_n;

  logic                 pend_found_q;
  logic [INDEX_W-1:0]   pend_pos_q;
  logic                 res_valid_q, res_found_q;
  logic [INDEX_W-1:0]   res_pos_q;

  logic in_acc, slot_free, start, advance, finish, load_out;

  generate
    if (EW <= VALUE_W) begin : g_narrow
      assign wr_elem = write_value_i[EW-1:0];
      assign key_in  = search_key_i[EW-1:0];
    end else begin : g_wide
      assign wr_elem = {{(EW-VALUE_W){write_value_i[VALUE_W-1]}}, write_value_i};
      assign key_in  = {{(EW-VALUE_W){search_key_i[VALUE_W-1]}}, search_key_i};
    end
  endgenerate

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !res_valid_q || !out_stall_i;

  always_comb begin
    wr_idx_ext = RW'(write_index_i);
    wr_ok      = (wr_idx_ext < Depth);
    lo0        = RW'(low_index_i);
    hi_ext     = {{(RW-HIGH_W){high_index_i[HIGH_W-1]}}, high_index_i};
    hi0        = (hi_ext > DMax) ? DMax : hi_ext;
    empty0     = (lo0 > hi0);
    sum0       = lo0 + hi0;
    mid0       = sum0 >>> 1;
  end

  bsst_step #(
    .RW (RW),
    .EW (EW)
  ) u_step (
    .elem_i  (rd_q),
    .key_i   (key_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .mid_i   (mid_q),
    .cmp_o   (cmp),
    .lo_o    (lo_n),
    .hi_o    (hi_n),
    .mid_o   (mid_n),
    .empty_o (empty_n)
  );

  always_comb begin
    start    = in_acc && (opcode_i == OP_SEARCH);
    advance  = (state_q == S_SEARCH) && !cmp.hit && !empty_n;
    finish   = (state_q == S_SEARCH) && (cmp.hit || empty_n);
    load_out = (state_q == S_DONE) && slot_free;
    mem_we   = in_acc && (opcode_i == OP_WRITE) && wr_ok;
    wr_addr  = wr_idx_ext[IDX_W-1:0];
    mem_re   = (start && !empty0) || advance;
    rd_addr  = (state_q == S_IDLE) ? mid0[IDX_W-1:0] : mid_n[IDX_W-1:0];
    state_d  = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = empty0 ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (finish) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_elem;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      key_q        <= key_in;
      lo_q         <= lo0;
      hi_q         <= hi0;
      mid_q        <= mid0;
      pend_found_q <= 1'b0;
      pend_pos_q   <= '0;
    end else if (advance) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end else if (finish) begin
      pend_found_q <= cmp.hit;
      pend_pos_q   <= cmp.hit ? mid_q[INDEX_W-1:0] : '0;
    end
    if (load_out) begin
      res_found_q <= pend_found_q;
      res_pos_q   <= pend_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign found_o     = res_found_q;
  assign position_o  = res_pos_q;

endmodule
`default_nettype wire

// ----- src/bsst_checker.sv -----
// Port-level assertions for the sorted table search block, bound to the top level.
`default_nettype none
module bsst_assert (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         opcode_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         found_o,
  input wire logic [bsst_pkg::INDEX_W-1:0] position_o
);
  import bsst_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(found_o) && $stable(position_o))
    else $error("stalled result item changed");

  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_WRITE) |=> !in_stall_o)
    else $error("write item did not complete in one cycle");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_SEARCH) |=> in_stall_o)
    else $error("search item did not hold off input");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (position_o == '0))
    else $error("miss reported with non-zero position");

endmodule

bind binary_search_sorted_table_core bsst_assert u_bsst_assert (.*);
`default_nettype wire

// ----- bench/bsst_checker.sv -----
// Result predictor and scoreboard for the sorted table search core.
module bsst_checker
  import bsst_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic                      opcode_i,
  input  wire logic [INDEX_W-1:0]        write_index_i,
  input  wire logic signed [VALUE_W-1:0] write_value_i,
  input  wire logic signed [VALUE_W-1:0] search_key_i,
  input  wire logic [INDEX_W-1:0]        low_index_i,
  input  wire logic signed [HIGH_W-1:0]  high_index_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_stall_i,
  input  wire logic                      found_i,
  input  wire logic [INDEX_W-1:0]        position_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);

  localparam int DEPTH = 1 << INDEX_W;

  typedef struct {
    logic               found;
    logic [INDEX_W-1:0] position;
  } search_answer_t;

  logic signed [VALUE_W-1:0] element_mem [DEPTH];
  search_answer_t            answer_q [$];
  int                        fail_count = 0;
  int                        pending    = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = pending;

  function automatic search_answer_t lookup_key(input logic signed [VALUE_W-1:0] key,
                                                input logic [INDEX_W-1:0]        lo_idx,
                                                input logic signed [HIGH_W-1:0]  hi_idx);
    search_answer_t ans;
    int             lo;
    int             hi;
    int             mid;
    logic           done;
    ans.found    = 1'b0;
    ans.position = '0;
    lo           = lo_idx;
    hi           = hi_idx;
    done         = 1'b0;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (!done && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (element_mem[mid] > key) begin
        hi = mid - 1;
      end else if (element_mem[mid] < key) begin
        lo = mid + 1;
      end else begin
        ans.found    = 1'b1;
        ans.position = INDEX_W'(mid);
        done         = 1'b1;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin : watch
    search_answer_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual found %0b position %0d",
                   $time, found_i, position_i);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (found_i !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, found_i);
            fail_count++;
          end
          if (position_i !== want.position) begin
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, want.position, position_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_WRITE) begin
          element_mem[write_index_i] = write_value_i;
        end else begin
          answer_q.push_back(lookup_key(search_key_i, low_index_i, high_index_i));
        end
      end
      pending = answer_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Stimulus, reset, handshake pacing and verdict for the sorted table search core.
module tb_top;
  import bsst_pkg::*;

  localparam int     DEPTH        = 1 << INDEX_W;
  localparam int     IDLE_LIMIT   = 5000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     STEP         = 4194304;
  localparam longint MIN_VAL      = -64'sd2147483648;
  localparam longint MAX_VAL      = 64'sd2147483647;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      opcode      = OP_WRITE;
  logic [INDEX_W-1:0]        write_index = '0;
  logic signed [VALUE_W-1:0] write_value = '0;
  logic signed [VALUE_W-1:0] search_key  = '0;
  logic [INDEX_W-1:0]        low_index   = '0;
  logic signed [HIGH_W-1:0]  high_index  = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic                      found;
  logic [INDEX_W-1:0]        position;

  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  logic timed_out = 1'b0;
  int   fail_count;
  int   outstanding;

  logic signed [VALUE_W-1:0] shadow_mem [DEPTH];

  always #5 clk = ~clk;

  binary_search_sorted_table_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .write_index_i (write_index),
    .write_value_i (write_value),
    .search_key_i  (search_key),
    .low_index_i   (low_index),
    .high_index_i  (high_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .found_o       (found),
    .position_o    (position)
  );

  bsst_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .write_index_i (write_index),
    .write_value_i (write_value),
    .search_key_i  (search_key),
    .low_index_i   (low_index),
    .high_index_i  (high_index),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .found_i       (found),
    .position_i    (position),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic                      op,
                           input logic [INDEX_W-1:0]        widx,
                           input logic signed [VALUE_W-1:0] wval,
                           input logic signed [VALUE_W-1:0] key,
                           input logic [INDEX_W-1:0]        lo,
                           input logic signed [HIGH_W-1:0]  hi);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    write_index <= widx;
    write_value <= wval;
    search_key  <= key;
    low_index   <= lo;
    high_index  <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_entry(input int idx, input logic signed [VALUE_W-1:0] val);
    shadow_mem[idx] = val;
    send_item(OP_WRITE, INDEX_W'(idx), val, $urandom, INDEX_W'($urandom), HIGH_W'($urandom));
  endtask

  task automatic search(input logic signed [VALUE_W-1:0] key, input int lo, input int hi);
    send_item(OP_SEARCH, INDEX_W'($urandom), $urandom, key, INDEX_W'(lo), HIGH_W'(hi));
  endtask

  task automatic random_write();
    int                        idx;
    longint                    lo_v;
    longint                    hi_v;
    longint                    span;
    logic signed [VALUE_W-1:0] val;
    idx = $urandom_range(DEPTH - 1);
    if ($urandom_range(99) < 8) begin
      val = $urandom;
    end else begin
      lo_v = (idx == 0) ? MIN_VAL : longint'(shadow_mem[idx-1]);
      hi_v = (idx == DEPTH - 1) ? MAX_VAL : longint'(shadow_mem[idx+1]);
      if (hi_v < lo_v) begin
        val = shadow_mem[idx];
      end else begin
        span = hi_v - lo_v + 1;
        val  = VALUE_W'(lo_v + longint'({$urandom, $urandom} >> 1) % span);
      end
    end
    write_entry(idx, val);
  endtask

  task automatic random_search();
    int                        lo;
    int                        hi;
    int                        j;
    int                        pick;
    logic signed [VALUE_W-1:0] key;
    pick = $urandom_range(99);
    lo   = $urandom_range(DEPTH - 1);
    if (pick < 70) begin
      hi = lo + $urandom_range(15);
      if (hi > DEPTH - 1) hi = DEPTH - 1;
    end else if (pick < 90) begin
      lo = $urandom_range(63);
      hi = $urandom_range(DEPTH - 1, lo);
    end else begin
      hi = $urandom_range(2 * DEPTH - 1) - DEPTH;
    end
    j    = (hi >= lo) ? $urandom_range(hi, lo) : lo;
    pick = $urandom_range(99);
    if (pick < 60) key = shadow_mem[j];
    else if (pick < 85) key = shadow_mem[j] + ($urandom_range(1) ? 1 : -1);
    else key = $urandom;
    search(key, lo, hi);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      if ($urandom_range(99) < 30) random_write();
      else random_search();
    end
  endtask

  task automatic run_stimulus();
    longint                    v;
    logic signed [VALUE_W-1:0] saved;
    for (int i = 0; i < DEPTH; i++) begin
      v = MIN_VAL + longint'(i) * STEP;
      if (i == DEPTH - 1) v = v + STEP - 1;
      else if (i != 0) v = v + $urandom_range(STEP - 1);
      write_entry(i, VALUE_W'(v));
    end

    search(shadow_mem[0], 0, DEPTH - 1);
    search(shadow_mem[DEPTH-1], 0, DEPTH - 1);
    search(shadow_mem[511], 0, DEPTH - 1);
    search(shadow_mem[5] + 1, 0, DEPTH - 1);
    search(shadow_mem[300], 0, -1);
    search(shadow_mem[0], 0, -DEPTH);
    search(shadow_mem[DEPTH-1], DEPTH - 1, DEPTH - 2);
    search(shadow_mem[40], 41, 40);
    search(shadow_mem[DEPTH-1], DEPTH - 1, DEPTH - 1);
    search(shadow_mem[512], 512, 512);
    search(shadow_mem[513], 512, 512);
    search(shadow_mem[700], 0, 699);
    write_entry(301, shadow_mem[300]);
    search(shadow_mem[300], 290, 310);
    saved = shadow_mem[700];
    write_entry(700, VALUE_W'(MAX_VAL));
    search(shadow_mem[650], 0, DEPTH - 1);
    search(VALUE_W'(MAX_VAL), 0, DEPTH - 1);
    search(saved, 600, 800);
    write_entry(700, saved);
    search(saved, 0, DEPTH - 1);

    run_phase(0, 0, 30);
    run_phase(81, 0, 30);
    run_phase(0, 81, 30);
    run_phase(13, 13, 30);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    repeat (60) random_search();
    run_phase(0, 0, 20);
    in_valid <= 1'b0;
  endtask

  initial begin
    fork
      begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_stimulus();
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
          @(posedge clk);
          if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
          else idle_cycles++;
        end
        timed_out = 1'b1;
      end
    join_any
    if (timed_out) begin
      $display("*** FAILED ***");
    end else if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bsst_pkg.sv
src/bsst_step.sv
src/binary_search_sorted_table_core.sv
src/bsst_checker.sv
bench/bsst_checker.sv
bench/tb_top.sv
